@@ rtl/core/mbrf_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the request framer.
// No dependencies; every module of the framer imports this package.
`default_nettype none

package mbrf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [6:0] MAX_REGS = 7'd123;

  localparam logic [7:0]  FUNC_READ_COILS  = 8'h01;
  localparam logic [7:0]  FUNC_WRITE_COIL  = 8'h05;
  localparam logic [15:0] COIL_ON          = 16'hFF00;
  localparam logic [15:0] COIL_OFF         = 16'h0000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ        = 2'd0,
    OP_WRITE_ONE   = 2'd1,
    OP_WRITE_START = 2'd2,
    OP_WRITE_VALUE = 2'd3
  } op_e;

  // One classified request: up to seven payload bytes, optional CRC tail.
  typedef struct packed {
    logic [7:0][7:0] data;
    logic [2:0]      nbytes;
    logic            restart;
    logic            tail;
    logic            err;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/modbus_rtu_request_framer.sv @@
// Modbus RTU request framer top level: front end, job queue, back end.
// Depends on mbrf_pkg, mbrf_front, mbrf_queue and mbrf_back.
//
// Input channel (in_valid_i / in_stall_o) takes one request per cycle with
// op_i and its fields; in_stall_o rises only while the two-entry job queue
// is full. Output channel (out_valid_o / out_stall_i) gives one frame byte
// per cycle with frame_end_o on the last byte of a frame and seq_error_o on
// a single error byte (value without an open frame, or a bad start count).
// Read and write-single requests give 8 bytes, a write-multiple start 7,
// a value 2 (4 with the CRC tail on the last value), an error 1.
// An accepted request passes the job queue, the back end's job register
// and the output register before its first byte appears. Throughput is
// one output byte per cycle while out_stall_i is low, set by the back end.
// Reset clears the queue, the output valid bit, the open-frame tracking and
// sets the CRC to 0xFFFF. While out_stall_i is high the output byte holds,
// the back end waits, and the queue fills before the input stalls.
`default_nettype none

module modbus_rtu_request_framer
  import mbrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  slave_id_i,
  input  wire logic [7:0]  func_code_i,
  input  wire logic [15:0] start_address_i,
  input  wire logic [15:0] end_address_i,
  input  wire logic [15:0] reg_value_i,
  input  wire logic [6:0]  value_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic             frame_end_o,
  output logic             seq_error_o
);

  job_t push_job, head_job;
  logic full, nonempty, pop, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mbrf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .op_i            (op_i),
    .slave_id_i      (slave_id_i),
    .func_code_i     (func_code_i),
    .start_address_i (start_address_i),
    .end_address_i   (end_address_i),
    .reg_value_i     (reg_value_i),
    .value_count_i   (value_count_i),
    .job_o           (push_job)
  );

  mbrf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .head_o     (head_job)
  );

  mbrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nonempty_i   (nonempty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o),
    .seq_error_o  (seq_error_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/mbrf_front.sv @@
// Front end: accepts requests, tracks the open write-multiple frame and
// classifies each request into a job for the queue. Uses mbrf_pkg.
`default_nettype none

module mbrf_front
  import mbrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  slave_id_i,
  input  wire logic [7:0]  func_code_i,
  input  wire logic [15:0] start_address_i,
  input  wire logic [15:0] end_address_i,
  input  wire logic [15:0] reg_value_i,
  input  wire logic [6:0]  value_count_i,
  output job_t             job_o
);

  logic       frame_open_q, frame_open_d;
  logic [6:0] values_left_q, values_left_d;
  logic [15:0] addr;
  logic [15:0] word;
  op_e         op;

  assign op   = op_e'(op_i);
  assign addr = start_address_i - 16'd1;

  always_comb begin
    job_o         = '0;
    frame_open_d  = frame_open_q;
    values_left_d = values_left_q;
    word          = reg_value_i;

    case (op)
      OP_WRITE_VALUE: begin
        if (!frame_open_q || values_left_q == 7'd0) begin
          job_o.nbytes = 3'd1;
          job_o.err    = 1'b1;
        end else begin
          job_o.data[0] = reg_value_i[15:8];
          job_o.data[1] = reg_value_i[7:0];
          job_o.nbytes  = 3'd2;
          job_o.tail    = (values_left_q == 7'd1);
          values_left_d = values_left_q - 7'd1;
          frame_open_d  = (values_left_q != 7'd1);
        end
      end
      OP_WRITE_START: begin
        job_o.restart = 1'b1;
        frame_open_d  = 1'b0;
        values_left_d = 7'd0;
        if (value_count_i == 7'd0 || value_count_i > MAX_REGS) begin
          job_o.nbytes = 3'd1;
          job_o.err    = 1'b1;
        end else begin
          job_o.data[0] = slave_id_i;
          job_o.data[1] = func_code_i;
          job_o.data[2] = addr[15:8];
          job_o.data[3] = addr[7:0];
          job_o.data[4] = 8'h00;
          job_o.data[5] = {1'b0, value_count_i};
          job_o.data[6] = {value_count_i, 1'b0};
          job_o.nbytes  = 3'd7;
          values_left_d = value_count_i;
          frame_open_d  = 1'b1;
        end
      end
      default: begin
        if (op == OP_READ) begin
          word = end_address_i - start_address_i + 16'd1;
        end else if (func_code_i == FUNC_READ_COILS || func_code_i == FUNC_WRITE_COIL) begin
          word = (reg_value_i != 16'd0) ? COIL_ON : COIL_OFF;
        end
        job_o.restart = 1'b1;
        job_o.data[0] = slave_id_i;
        job_o.data[1] = func_code_i;
        job_o.data[2] = addr[15:8];
        job_o.data[3] = addr[7:0];
        job_o.data[4] = word[15:8];
        job_o.data[5] = word[7:0];
        job_o.nbytes  = 3'd6;
        job_o.tail    = 1'b1;
        frame_open_d  = 1'b0;
        values_left_d = 7'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q  <= 1'b0;
      values_left_q <= 7'd0;
    end else if (accept_i) begin
      frame_open_q  <= frame_open_d;
      values_left_q <= values_left_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mbrf_queue.sv @@
// Short job queue between front and back end.
// Depth and job type come from mbrf_pkg.
`default_nettype none

module mbrf_queue
  import mbrf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      nonempty_o,
  output job_t      head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mbrf_back.sv @@
// Back end: sends each job one byte per cycle, unless stalled, into the
// output register with a running CRC-16 and its tail. Uses mbrf_pkg.
`default_nettype none

module mbrf_back
  import mbrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       nonempty_i,
  input  job_t            head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            frame_end_o,
  output logic            seq_error_o
);

  job_t        job_q;
  logic        busy_q;
  logic [2:0]  idx_q;
  logic [15:0] crc_q, crc_d, crc_base;
  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;
  logic        err_q;
  logic        advance, emit, last, done, in_data;

  assign advance  = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && advance;
  assign in_data  = (idx_q < job_q.nbytes);
  assign last     = job_q.tail ? (idx_q == job_q.nbytes + 3'd1)
                               : (idx_q == job_q.nbytes - 3'd1);
  assign done     = emit && last;
  assign pop_o    = nonempty_i && (!busy_q || done);
  assign crc_base = (idx_q == 3'd0 && job_q.restart) ? CRC_INIT : crc_q;

  always_comb begin
    crc_d  = crc_q;
    byte_d = 8'h00;
    end_d  = 1'b0;
    if (job_q.err) begin
      end_d = 1'b1;
    end else if (in_data) begin
      byte_d = job_q.data[idx_q];
      crc_d  = crc_byte(crc_base, byte_d);
      end_d  = 1'b0;
    end else if (idx_q == job_q.nbytes) begin
      byte_d = crc_q[7:0];
    end else begin
      byte_d = crc_q[15:8];
      end_d  = 1'b1;
      crc_d  = CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 3'd0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        crc_q <= crc_d;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 3'd0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 3'd1;
      end
      if (advance) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (emit) begin
      byte_q <= byte_d;
      end_q  <= end_d;
      err_q  <= job_q.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign frame_end_o  = end_q;
  assign seq_error_o  = err_q;

endmodule

`default_nettype wire
